// ===== hdl/trimmed_range_after_three_removals_core_assert.svh =====
// Assertion macros for the trimmed range core.
`ifndef TRIMMED_RANGE_AFTER_THREE_REMOVALS_CORE_ASSERT_SVH
`define TRIMMED_RANGE_AFTER_THREE_REMOVALS_CORE_ASSERT_SVH

// Same-cycle implication, clocked on clk, off during reset.
`define TRAC_ASSERT_IMPL(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("trac: same-cycle check failed");

// Next-cycle implication, clocked on clk, off during reset.
`define TRAC_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("trac: next-cycle check failed");

`endif

// ===== hdl/trac_pkg.sv =====
// Shared types and constants for the trimmed range core.
`timescale 1ns / 1ps
package trac_pkg;

  localparam int DATA_W  = 32;
  localparam int RANGE_W = 32;

  typedef logic signed [DATA_W-1:0] sample_t;
  typedef logic [RANGE_W-1:0]       range_t;

  // queue fill status seen by the back end and the top-level input handshake
  typedef struct packed {
    logic empty;
    logic full;
  } trac_qstat_t;

endpackage

// ===== hdl/trac_front.sv =====
// Front end: accepts values and keeps the sorted smallest and largest lists.
`timescale 1ns / 1ps
module trac_front
  import trac_pkg::*;
#(
  parameter int KEEP = 4
) (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        acc,
  input  sample_t                     sample,
  input  logic                        last,
  output logic                        push,
  output logic [2*KEEP*DATA_W:0]      push_data
);

  localparam int CNT_W = $clog2(KEEP + 2);

  logic [CNT_W-1:0] cnt_r, cnt_nxt, cnt_inc;
  sample_t          sm_r [KEEP];
  sample_t          sm_nxt [KEEP];
  sample_t          lg_r [KEEP];
  sample_t          lg_nxt [KEEP];
  logic [KEEP-1:0]  keep_s, keep_l;
  logic             small_set;

  always_comb begin
    for (int j = 0; j < KEEP; j++) begin
      keep_s[j] = (cnt_r > CNT_W'(j)) && (sm_r[j] <= sample);
      keep_l[j] = (cnt_r > CNT_W'(j)) && (lg_r[j] >= sample);
    end
    sm_nxt[0] = keep_s[0] ? sm_r[0] : sample;
    lg_nxt[0] = keep_l[0] ? lg_r[0] : sample;
    for (int j = 1; j < KEEP; j++) begin
      sm_nxt[j] = keep_s[j] ? sm_r[j] : (keep_s[j-1] ? sample : sm_r[j-1]);
      lg_nxt[j] = keep_l[j] ? lg_r[j] : (keep_l[j-1] ? sample : lg_r[j-1]);
    end
  end

  always_comb begin
    cnt_inc   = (cnt_r > CNT_W'(KEEP)) ? cnt_r : cnt_r + CNT_W'(1);
    small_set = (cnt_inc <= CNT_W'(KEEP));
    cnt_nxt   = last ? '0 : cnt_inc;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r <= '0;
    end else if (acc) begin
      cnt_r <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (acc) begin
      for (int j = 0; j < KEEP; j++) begin
        sm_r[j] <= sm_nxt[j];
        lg_r[j] <= lg_nxt[j];
      end
    end
  end

  // request to the back end carries the updated lists of a finished set
  always_comb begin
    push      = acc && last;
    push_data = '0;
    push_data[2*KEEP*DATA_W] = small_set;
    for (int j = 0; j < KEEP; j++) begin
      push_data[j*DATA_W +: DATA_W]        = sm_nxt[j];
      push_data[(KEEP+j)*DATA_W +: DATA_W] = lg_nxt[j];
    end
  end

endmodule

// ===== hdl/trac_queue.sv =====
// Two-entry queue between the front and back ends.
`timescale 1ns / 1ps
module trac_queue
  import trac_pkg::*;
#(
  parameter int WIDTH = 257
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             push,
  input  logic [WIDTH-1:0] wr_data,
  input  logic             pop,
  output logic [WIDTH-1:0] rd_data,
  output trac_qstat_t      qstat
);

  logic [WIDTH-1:0] mem_r [2];
  logic             wr_ptr_r, rd_ptr_r;
  logic [1:0]       fill_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
      fill_r   <= 2'd0;
    end else begin
      if (push) wr_ptr_r <= ~wr_ptr_r;
      if (pop)  rd_ptr_r <= ~rd_ptr_r;
      case ({push, pop})
        2'b10:   fill_r <= fill_r + 2'd1;
        2'b01:   fill_r <= fill_r - 2'd1;
        default: fill_r <= fill_r;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (push) mem_r[wr_ptr_r] <= wr_data;
  end

  assign rd_data     = mem_r[rd_ptr_r];
  assign qstat.empty = (fill_r == 2'd0);
  assign qstat.full  = (fill_r == 2'd2);

endmodule

// ===== hdl/trac_back.sv =====
// Back end: differences of paired list entries and a registered minimum tree.
`timescale 1ns / 1ps
module trac_back
  import trac_pkg::*;
#(
  parameter int KEEP = 4
) (
  input  logic                   clk,
  input  logic                   rst_n,
  input  trac_qstat_t            qstat,
  input  logic [2*KEEP*DATA_W:0] rd_data,
  output logic                   pop,
  output logic                   out_valid,
  input  logic                   out_ready,
  output range_t                 out_range
);

  localparam int LVLS = $clog2(KEEP);
  localparam int P    = 1 << LVLS;

  range_t          lvl_r [LVLS+1][P];
  logic [LVLS:0]   vld_r;
  logic            adv;
  range_t          diff_c [KEEP];
  logic            small_set;

  assign adv = !vld_r[LVLS] || out_ready;
  assign pop = adv && !qstat.empty;
  assign small_set = rd_data[2*KEEP*DATA_W];

  always_comb begin
    for (int i = 0; i < KEEP; i++) begin
      logic signed [DATA_W:0] d;
      d = {rd_data[(2*KEEP-1-i)*DATA_W + DATA_W-1], rd_data[(2*KEEP-1-i)*DATA_W +: DATA_W]}
        - {rd_data[i*DATA_W + DATA_W-1], rd_data[i*DATA_W +: DATA_W]};
      diff_c[i] = (small_set || d[DATA_W]) ? '0 : range_t'(d[RANGE_W-1:0]);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else if (adv) begin
      vld_r <= {vld_r[LVLS-1:0], !qstat.empty};
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      for (int k = 0; k < P; k++) begin
        lvl_r[0][k] <= (k < KEEP) ? diff_c[k] : '1;
      end
      for (int l = 1; l <= LVLS; l++) begin
        for (int k = 0; k < (P >> l); k++) begin
          lvl_r[l][k] <= (lvl_r[l-1][2*k] < lvl_r[l-1][2*k+1]) ?
                         lvl_r[l-1][2*k] : lvl_r[l-1][2*k+1];
        end
      end
    end
  end

  assign out_valid = vld_r[LVLS];
  assign out_range = lvl_r[LVLS][0];

endmodule

// ===== hdl/trimmed_range_after_three_removals_core.sv =====
// Top level of the trimmed range core.
//
//  channel  | direction | tdata (low bit up)     | tlast
//  in_      | request   | sample_value [31:0]    | end_of_set
//  out_     | result    | min_range [31:0]       | -
//
// Takes one value per cycle while the queue is not full; the sorted-list insertion is combinational.
// A result's lists enter the queue with its last value, then pass the difference register and the min-tree levels.
// Reset (rst_n low, synchronous) clears the count, queue and pipeline valids.
// A stalled output holds the pipeline; the input stalls when the queue is full.
`timescale 1ns / 1ps
`include "trimmed_range_after_three_removals_core_assert.svh"
module trimmed_range_after_three_removals_core
  import trac_pkg::*;
#(
  parameter int REMOVALS = 3
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [31:0] in_tdata,   // [31:0] sample_value
  input  logic        in_tlast,
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [31:0] out_tdata   // [31:0] min_range
);

  localparam int KEEP = REMOVALS + 1;
  localparam int QW   = 2 * KEEP * DATA_W + 1;

  logic          acc, push, pop;
  logic [QW-1:0] push_data, rd_data;
  trac_qstat_t   qstat;

  assign in_tready = !qstat.full;
  assign acc       = in_tvalid && in_tready;

  trac_front #(.KEEP(KEEP)) u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .acc       (acc),
    .sample    (sample_t'(in_tdata)),
    .last      (in_tlast),
    .push      (push),
    .push_data (push_data)
  );

  trac_queue #(.WIDTH(QW)) u_queue (
    .clk     (clk),
    .rst_n   (rst_n),
    .push    (push),
    .wr_data (push_data),
    .pop     (pop),
    .rd_data (rd_data),
    .qstat   (qstat)
  );

  trac_back #(.KEEP(KEEP)) u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .qstat     (qstat),
    .rd_data   (rd_data),
    .pop       (pop),
    .out_valid (out_tvalid),
    .out_ready (out_tready),
    .out_range (out_tdata)
  );

  `TRAC_ASSERT_IMPL(a_queue_status, qstat.full, !qstat.empty)
  `TRAC_ASSERT_IMPL(a_no_push_full, push, !qstat.full)
  `TRAC_ASSERT_IMPL(a_no_pop_empty, pop, !qstat.empty)
  `TRAC_ASSERT_NEXT(a_push_fills, push && !pop, !qstat.empty)

endmodule
